// ===== hdl/nps_pkg.sv =====
// ============================================================================
// nps_pkg: shared types and constants of the monophonic note stack
// Event and result items, stack entry layout, event kinds, register indexes,
// and the waveform reduction that takes a controller value modulo six.
// ============================================================================
package nps_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam int MIDI_W     = 7;
    localparam int KIND_W     = 2;
    localparam int WAVE_W     = 3;
    localparam int HELD_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [KIND_W-1:0] KIND_ON  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OFF = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CC  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WAVE_CC   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DETUNE_CC = 1'd1;

    localparam logic [MIDI_W-1:0] NOTE_RESET      = 7'd60;
    localparam logic [MIDI_W-1:0] WAVE_CC_RESET   = 7'd70;
    localparam logic [MIDI_W-1:0] DETUNE_CC_RESET = 7'd71;

    localparam int WAVE_COUNT = 6;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MIDI_W-1:0] note;
        logic [MIDI_W-1:0] velocity;
        logic [MIDI_W-1:0] ctrl_num;
        logic [MIDI_W-1:0] control_value;
    } t_event;

    typedef struct packed {
        logic              gate;
        logic [MIDI_W-1:0] current_note;
        logic [MIDI_W-1:0] current_velocity;
        logic [WAVE_W-1:0] waveform;
        logic [MIDI_W-1:0] detune_code;
        logic [HELD_W-1:0] held_count;
        logic              overflow;
    } t_result;

    // one stack entry as kept in memory
    typedef struct packed {
        logic [MIDI_W-1:0] note;
        logic [MIDI_W-1:0] vel;
    } t_entry;

    // voice state handed from the stack core to the top level
    typedef struct packed {
        logic              gate;
        logic [MIDI_W-1:0] note;
        logic [MIDI_W-1:0] velocity;
        logic [HELD_W-1:0] held_count;
        logic              overflow;
    } t_voice;

    // value modulo six by conditional subtraction of 96, 48, 24, 12, 6
    function automatic logic [WAVE_W-1:0] wave_of(input logic [MIDI_W-1:0] value);
        logic [MIDI_W-1:0] rem;
        rem = value;
        for (int k = 4; k >= 0; k--) begin
            if (rem >= MIDI_W'(WAVE_COUNT << k)) begin
                rem = rem - MIDI_W'(WAVE_COUNT << k);
            end
        end
        return rem[WAVE_W-1:0];
    endfunction

endpackage

// ===== hdl/nps_evt_if.sv =====
// ============================================================================
// nps_evt_if: event channel
// Valid/ready channel that carries one MIDI event item.
// ============================================================================
interface nps_evt_if;
    import nps_pkg::*;

    logic   valid;
    logic   ready;
    t_event data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/nps_res_if.sv =====
// ============================================================================
// nps_res_if: result channel
// Valid/ready channel that carries one voice result item.
// ============================================================================
interface nps_res_if;
    import nps_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/mono_note_priority_stack.sv =====
// ============================================================================
// mono_note_priority_stack: monophonic voice selection by last-note priority
// Takes MIDI note and control events, keeps the held notes on a stack and
// reports the voice state after every event.
// ============================================================================
// Usage:
//   i_evt carries one event item (kind, note, velocity, control number and
//   value); o_res returns exactly one result item per event, in order, with
//   gate, current note and velocity, waveform, detune code, held count and
//   the overflow flag. Both are valid/ready channels.
//   A control change, an ignored item, a note-off on an empty stack and a
//   note-on into a stack with room need no stack walk. A note-off searches
//   the entries for the note, moves those above the match down one place,
//   then reads the new top unless the stack is empty; a note-on into a full
//   stack shifts every entry down to drop the oldest. The stack memory has
//   one read and one write port, so search and compaction walk the stack at
//   one entry per cycle; one event is in the core at a time, so the next
//   event is taken only once the core is through with the current one.
//   A finished result sits in the output register, so the next event is
//   taken while o_res is stalled; the core holds its own result until that
//   register frees up, and i_evt.ready drops meanwhile.
//   Reset (synchronous, active low) empties the stack, closes the gate, sets
//   the note to 60, waveform sine, detune 0, and the control numbers to 70
//   and 71. No memory clearing is needed. Write control numbers through
//   i_cfg_* only while no event is in flight.
// ============================================================================
module mono_note_priority_stack #(
    parameter int STACK_DEPTH = nps_pkg::STACK_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    nps_evt_if.sink                          i_evt,
    nps_res_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [nps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [nps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import nps_pkg::*;

    logic   core_idle;
    logic   core_done;
    logic   accept;
    logic   take;
    t_voice voice;
    t_event evt;

    logic [MIDI_W-1:0] r_wave_cc;
    logic [MIDI_W-1:0] r_detune_cc;
    logic [WAVE_W-1:0] r_wave, n_wave;
    logic [MIDI_W-1:0] r_detune, n_detune;
    logic              r_out_valid;
    t_result           r_out;

    assign evt         = i_evt.data;
    // take an event whenever the core is free, even with a result waiting
    assign i_evt.ready = core_idle;
    assign accept      = i_evt.valid && core_idle;
    // move a finished result into the output register once it has room
    assign take        = core_done && (!r_out_valid || o_res.ready);

    nps_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_evt   (evt),
        .i_take  (take),
        .o_idle  (core_idle),
        .o_done  (core_done),
        .o_voice (voice)
    );

    // control change: waveform number wins when both numbers match
    always_comb begin
        n_wave   = r_wave;
        n_detune = r_detune;
        if (accept && (evt.kind == KIND_CC)) begin
            priority if (evt.ctrl_num == r_wave_cc) begin
                n_wave = wave_of(evt.control_value);
            end else if (evt.ctrl_num == r_detune_cc) begin
                n_detune = evt.control_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_cc   <= WAVE_CC_RESET;
            r_detune_cc <= DETUNE_CC_RESET;
            r_wave      <= '0;
            r_detune    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WAVE_CC:   r_wave_cc   <= i_cfg_data;
                    REG_DETUNE_CC: r_detune_cc <= i_cfg_data;
                endcase
            end
            r_wave   <= n_wave;
            r_detune <= n_detune;
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload: hold until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= '{gate:             voice.gate,
                       current_note:     voice.note,
                       current_velocity: voice.velocity,
                       waveform:         r_wave,
                       detune_code:      r_detune,
                       held_count:       voice.held_count,
                       overflow:         voice.overflow};
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

// ===== hdl/nps_core.sv =====
// ============================================================================
// nps_core: note stack sequencer
// Holds the note stack in a synchronous memory, pushes, searches and
// compacts it one entry per cycle, and keeps the current voice.
// ============================================================================
module nps_core #(
    parameter int STACK_DEPTH = nps_pkg::STACK_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  nps_pkg::t_event i_evt,
    input  logic            i_take,
    output logic            o_idle,
    output logic            o_done,
    output nps_pkg::t_voice o_voice
);
    import nps_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_TOP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    t_entry r_mem [STACK_DEPTH];
    t_entry r_rdata;

    logic [1:0]        r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_rd_valid, n_rd_valid;
    logic              r_found, n_found;
    logic              r_mode_ovf, n_mode_ovf;
    logic              r_ovf, n_ovf;
    logic [MIDI_W-1:0] r_note, n_note;
    logic [MIDI_W-1:0] r_vel, n_vel;
    logic [MIDI_W-1:0] r_vnote, n_vnote;
    logic [MIDI_W-1:0] r_vvel, n_vvel;
    logic              r_gate, n_gate;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic          is_on;
    logic          is_off;
    logic [CW-1:0] cnt_new;

    assign is_on   = (i_evt.kind == KIND_ON) && (i_evt.velocity != '0);
    assign is_off  = ((i_evt.kind == KIND_ON) && (i_evt.velocity == '0))
                  || (i_evt.kind == KIND_OFF);
    assign cnt_new = r_cnt - CW'(r_found);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_rd_idx   = r_rd_idx;
        n_rd_valid = r_rd_valid;
        n_found    = r_found;
        n_mode_ovf = r_mode_ovf;
        n_ovf      = r_ovf;
        n_note     = r_note;
        n_vel      = r_vel;
        n_vnote    = r_vnote;
        n_vvel     = r_vvel;
        n_gate     = r_gate;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '{note: r_note, vel: r_vel};
        mem_re     = 1'b0;
        mem_raddr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_note     = i_evt.note;
                    n_vel      = i_evt.velocity;
                    n_ovf      = 1'b0;
                    n_found    = 1'b0;
                    n_mode_ovf = 1'b0;
                    n_rd_valid = 1'b0;
                    n_idx      = '0;
                    n_state    = S_DONE;
                    if (is_on) begin
                        if (r_cnt < FULL) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_cnt[AW-1:0];
                            mem_wdata = '{note: i_evt.note, vel: i_evt.velocity};
                            n_cnt     = r_cnt + CW'(1);
                            n_vnote   = i_evt.note;
                            n_vvel    = i_evt.velocity;
                            n_gate    = 1'b1;
                        end else begin
                            // drop the oldest: shift entries 1.. down by one
                            n_ovf      = 1'b1;
                            n_mode_ovf = 1'b1;
                            n_found    = 1'b1;
                            n_idx      = CW'(1);
                            n_state    = S_SCAN;
                        end
                    end else if (is_off) begin
                        if (r_cnt == '0) begin
                            n_gate = 1'b0;
                            n_vvel = '0;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_idx < r_cnt) begin
                    mem_re     = 1'b1;
                    mem_raddr  = r_idx[AW-1:0];
                    n_idx      = r_idx + CW'(1);
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_idx[AW-1:0];
                end else begin
                    n_rd_valid = 1'b0;
                end
                // past the match, move each entry down one place
                if (r_rd_valid) begin
                    if (r_found) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_rd_idx - AW'(1);
                        mem_wdata = r_rdata;
                    end else if (r_rdata.note == r_note) begin
                        n_found = 1'b1;
                    end
                end
                if ((r_idx >= r_cnt) && !r_rd_valid) begin
                    if (r_mode_ovf) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(STACK_DEPTH - 1);
                        mem_wdata = '{note: r_note, vel: r_vel};
                        n_vnote   = r_note;
                        n_vvel    = r_vel;
                        n_gate    = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        n_cnt = cnt_new;
                        if (cnt_new == '0) begin
                            n_gate  = 1'b0;
                            n_vvel  = '0;
                            n_state = S_DONE;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = AW'(cnt_new - CW'(1));
                            n_state   = S_TOP;
                        end
                    end
                end
            end
            S_TOP: begin
                n_vnote = r_rdata.note;
                n_vvel  = r_rdata.vel;
                n_gate  = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_idx      <= '0;
            r_rd_valid <= 1'b0;
            r_found    <= 1'b0;
            r_mode_ovf <= 1'b0;
            r_ovf      <= 1'b0;
            r_vnote    <= NOTE_RESET;
            r_vvel     <= '0;
            r_gate     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_idx      <= n_idx;
            r_rd_valid <= n_rd_valid;
            r_found    <= n_found;
            r_mode_ovf <= n_mode_ovf;
            r_ovf      <= n_ovf;
            r_vnote    <= n_vnote;
            r_vvel     <= n_vvel;
            r_gate     <= n_gate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_note   <= n_note;
        r_vel    <= n_vel;
        r_rd_idx <= n_rd_idx;
    end

    assign o_idle  = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE);
    assign o_voice = '{gate:       r_gate,
                       note:       r_vnote,
                       velocity:   r_vvel,
                       held_count: HELD_W'(r_cnt),
                       overflow:   r_ovf};

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL)
        else $error("note stack count beyond depth");

    a_gate_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gate == (r_cnt != '0))
        else $error("gate disagrees with stack occupancy");

    a_closed_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_gate |-> (r_vvel == '0))
        else $error("velocity nonzero with gate closed");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_cnt == FULL))
        else $error("overflow flagged on a stack that is not full");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("stack memory read and write hit the same entry");
`endif

endmodule

// ===== verif/nps_voice_check.sv =====
// ============================================================================
// nps_voice_check: voice state predictor and result comparator
// Watches the event, result and register ports of the note stack, keeps its
// own copy of the held notes and the voice, and compares each result item
// field by field with the oldest prediction.
// ============================================================================
module nps_voice_check #(
    parameter int STACK_DEPTH = nps_pkg::STACK_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_evt_valid,
    input  logic                            i_evt_ready,
    input  nps_pkg::t_event                 i_evt_data,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  nps_pkg::t_result                i_res_data,
    input  logic                            i_cfg_we,
    input  logic [nps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [nps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import nps_pkg::*;

    localparam int REPORT_MAX = 40;

    t_entry            held_notes [STACK_DEPTH];
    int                held_total;
    logic              voice_gate;
    logic [MIDI_W-1:0] voice_note;
    logic [MIDI_W-1:0] voice_vel;
    logic [WAVE_W-1:0] wave_sel;
    logic [MIDI_W-1:0] detune_val;
    logic [MIDI_W-1:0] wave_cc_num;
    logic [MIDI_W-1:0] detune_cc_num;

    t_result           voice_expected_q [$];
    t_result           want;
    int                mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic void clear_voice();
        held_total    = 0;
        voice_gate    = 1'b0;
        voice_note    = NOTE_RESET;
        voice_vel     = '0;
        wave_sel      = '0;
        detune_val    = '0;
        wave_cc_num   = WAVE_CC_RESET;
        detune_cc_num = DETUNE_CC_RESET;
    endfunction

    // drop the entry at pos and close the gap above it
    function automatic void drop_entry(input int pos);
        int i;
        for (i = pos; i + 1 < held_total; i++) begin
            held_notes[i] = held_notes[i + 1];
        end
        held_total--;
    endfunction

    // push a note; a full stack loses its oldest entry first
    function automatic logic press_note(input logic [MIDI_W-1:0] note,
                                        input logic [MIDI_W-1:0] vel);
        logic full;
        full = (held_total >= STACK_DEPTH);
        if (full) begin
            drop_entry(0);
        end
        held_notes[held_total].note = note;
        held_notes[held_total].vel  = vel;
        held_total++;
        voice_note = note;
        voice_vel  = vel;
        voice_gate = 1'b1;
        return full;
    endfunction

    // remove the oldest matching entry, then fall back to the newest held note
    function automatic void release_note(input logic [MIDI_W-1:0] note);
        int i;
        int hit;
        hit = -1;
        for (i = 0; i < held_total; i++) begin
            if (hit < 0 && held_notes[i].note == note) begin
                hit = i;
            end
        end
        if (hit >= 0) begin
            drop_entry(hit);
        end
        if (held_total > 0) begin
            voice_note = held_notes[held_total - 1].note;
            voice_vel  = held_notes[held_total - 1].vel;
            voice_gate = 1'b1;
        end else begin
            voice_gate = 1'b0;
            voice_vel  = '0;
        end
    endfunction

    function automatic t_result voice_after_event(input t_event ev);
        t_result r;
        logic    dropped;
        dropped = 1'b0;
        case (ev.kind)
            KIND_ON: begin
                if (ev.velocity != '0) begin
                    dropped = press_note(ev.note, ev.velocity);
                end else begin
                    release_note(ev.note);
                end
            end
            KIND_OFF: begin
                release_note(ev.note);
            end
            KIND_CC: begin
                // waveform number wins when both registers hold the same number
                if (ev.ctrl_num == wave_cc_num) begin
                    wave_sel = WAVE_W'(ev.control_value % WAVE_COUNT);
                end else if (ev.ctrl_num == detune_cc_num) begin
                    detune_val = ev.control_value;
                end
            end
            default: begin
            end
        endcase
        r.gate             = voice_gate;
        r.current_note     = voice_note;
        r.current_velocity = voice_vel;
        r.waveform         = wave_sel;
        r.detune_code      = detune_val;
        r.held_count       = HELD_W'(held_total);
        r.overflow         = dropped;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [7:0] exp_val,
                                        input logic [7:0] act_val);
        if (act_val !== exp_val) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("t=%0t %s mismatch: expected %0d, actual %0d",
                         $time, field, exp_val, act_val);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_voice();
            voice_expected_q.delete();
        end else begin
            // results first: a result never belongs to an event taken at the same edge
            if (i_res_valid && i_res_ready) begin
                if (voice_expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("t=%0t unexpected result: expected none, actual %h",
                                 $time, i_res_data);
                    end
                end else begin
                    want = voice_expected_q.pop_front();
                    check_field("gate", 8'(want.gate), 8'(i_res_data.gate));
                    check_field("current_note", 8'(want.current_note),
                                8'(i_res_data.current_note));
                    check_field("current_velocity", 8'(want.current_velocity),
                                8'(i_res_data.current_velocity));
                    check_field("waveform", 8'(want.waveform), 8'(i_res_data.waveform));
                    check_field("detune_code", 8'(want.detune_code),
                                8'(i_res_data.detune_code));
                    check_field("held_count", 8'(want.held_count),
                                8'(i_res_data.held_count));
                    check_field("overflow", 8'(want.overflow), 8'(i_res_data.overflow));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WAVE_CC:   wave_cc_num   = i_cfg_data;
                    REG_DETUNE_CC: detune_cc_num = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_evt_valid && i_evt_ready) begin
                voice_expected_q.insert(voice_expected_q.size(),
                                        voice_after_event(i_evt_data));
            end
        end
        o_pending <= voice_expected_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// ============================================================================
// tb_top: stimulus and verdict for the monophonic note stack
// Drives MIDI event items through random sender gaps and receiver stalls,
// rewrites the two control numbers between phases, and reports the verdict
// from the failure count of the voice checker.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nps_pkg::*;

    localparam int DEPTH           = STACK_DEPTH_DEF;
    localparam int IDLE_MAX        = 16;
    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 250;
    // slowest legal gap between two handshakes, taken ten times over
    localparam int STALL_LIMIT     = 10 * (2 * IDLE_MAX + DEPTH + 8);
    localparam logic [MIDI_W-1:0] NOTE_BASE = 7'd48;
    // event kind the block ignores
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    nps_evt_if evt_ch ();
    nps_res_if res_ch ();

    int fail_count;
    int pending;
    int quiet_cycles = 0;

    // idling switches, changed per phase
    bit evt_idle_on = 1'b1;
    bit res_idle_on = 1'b1;

    // control numbers the block holds now, used to aim control changes
    logic [MIDI_W-1:0] wave_cc_sel   = WAVE_CC_RESET;
    logic [MIDI_W-1:0] detune_cc_sel = DETUNE_CC_RESET;

    // notes the player believes are held; aims note-offs at real entries
    logic [MIDI_W-1:0] held_q [$];

    always #6 i_clk = ~i_clk;

    mono_note_priority_stack #(
        .STACK_DEPTH (DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    nps_voice_check #(
        .STACK_DEPTH (DEPTH)
    ) u_voice_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt_valid  (evt_ch.valid),
        .i_evt_ready  (evt_ch.ready),
        .i_evt_data   (evt_ch.data),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res_data   (res_ch.data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Keep the player's view of the stack in step with what was sent.
    function automatic void track_held(input t_event ev);
        int i;
        int hit;
        if (ev.kind == KIND_ON && ev.velocity != '0) begin
            held_q.insert(held_q.size(), ev.note);
            if (held_q.size() > DEPTH) begin
                held_q.delete(0);
            end
        end else if (ev.kind == KIND_ON || ev.kind == KIND_OFF) begin
            hit = -1;
            for (i = 0; i < held_q.size(); i++) begin
                if (hit < 0 && held_q[i] == ev.note) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                held_q.delete(hit);
            end
        end
    endfunction

    // Items that leave the voice untouched: unknown kind or a stray control number.
    function automatic bit is_ignored(input t_event ev);
        return (ev.kind == KIND_NONE) ||
               (ev.kind == KIND_CC && ev.ctrl_num != wave_cc_sel &&
                ev.ctrl_num != detune_cc_sel);
    endfunction

    // Send one item: hold off for a random gap, then hold valid until taken.
    // Valid stays high after acceptance so a zero gap never toggles it.
    task automatic send_event(input t_event ev);
        int gap;
        gap = evt_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt_ch.valid <= 1'b1;
        evt_ch.data  <= ev;
        @(posedge i_clk);
        while (!evt_ch.ready) @(posedge i_clk);
        track_held(ev);
    endtask

    task automatic play(input logic [KIND_W-1:0] kind, input logic [MIDI_W-1:0] note,
                        input logic [MIDI_W-1:0] vel, input logic [MIDI_W-1:0] ccn,
                        input logic [MIDI_W-1:0] ccv);
        t_event ev;
        ev.kind           = kind;
        ev.note           = note;
        ev.velocity       = vel;
        ev.ctrl_num       = ccn;
        ev.control_value  = ccv;
        send_event(ev);
    endtask

    // Drop valid and wait until every predicted result has come back.
    // The pending count is registered, so wait for it to update before the first look.
    task automatic drain();
        evt_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    // Mostly a well-formed performance: presses, releases of held notes and
    // control changes aimed at the live numbers; a little noise on top.
    task automatic next_event(input int on_pct, input int off_pct, output t_event ev);
        int roll;
        roll              = $urandom_range(0, 99);
        ev.kind           = KIND_ON;
        ev.note           = MIDI_W'($urandom_range(0, 127));
        ev.velocity       = MIDI_W'($urandom_range(1, 127));
        ev.ctrl_num       = MIDI_W'($urandom_range(0, 127));
        ev.control_value  = MIDI_W'($urandom_range(0, 127));
        if (roll < on_pct) begin
            // a narrow window of notes makes duplicates on the stack likely
            if ($urandom_range(0, 4) != 0) begin
                ev.note = NOTE_BASE + MIDI_W'($urandom_range(0, 15));
            end
        end else if (roll < on_pct + off_pct) begin
            if (held_q.size() != 0 && $urandom_range(0, 9) != 0) begin
                ev.note = held_q[$urandom_range(0, held_q.size() - 1)];
            end
            if ($urandom_range(0, 3) == 0) begin
                ev.velocity = '0;
            end else begin
                ev.kind     = KIND_OFF;
                ev.velocity = MIDI_W'($urandom_range(0, 127));
            end
        end else if (roll < 97) begin
            ev.kind = KIND_CC;
            case ($urandom_range(0, 4))
                0, 1:    ev.ctrl_num = wave_cc_sel;
                2, 3:    ev.ctrl_num = detune_cc_sel;
                default: begin
                end
            endcase
        end else begin
            ev.kind = KIND_NONE;
        end
    endtask

    // Receiver: stall a random number of cycles per item, then take it.
    initial begin : result_sink
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = res_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    // Watchdog: end the run when no item moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        t_event ev;
        int     p;
        int     i;
        int     counted;
        int     on_pct;
        int     off_pct;

        evt_ch.valid <= 1'b0;
        evt_ch.data  <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= REG_WAVE_CC;
        i_cfg_data   <= '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part, control numbers at their reset values ---
        // release on an empty stack: gate stays closed, note 60 kept, velocity ignored
        play(KIND_OFF, 7'd0, 7'd127, 7'd0, 7'd0);
        // unknown kind with every field at its top value
        play(KIND_NONE, 7'd127, 7'd127, 7'd127, 7'd127);
        // waveform from 127 mod 6, detune at full scale, stray controller
        play(KIND_CC, 7'd0, 7'd0, WAVE_CC_RESET, 7'd127);
        play(KIND_CC, 7'd0, 7'd0, DETUNE_CC_RESET, 7'd127);
        play(KIND_CC, 7'd127, 7'd127, 7'd0, 7'd0);
        // fill the stack with repeated notes, one more press overflows it
        for (i = 0; i <= DEPTH; i++) begin
            play(KIND_ON, (i % 3 == 0) ? 7'd0 : (i % 3 == 1) ? 7'd127 : MIDI_W'(64 + i),
                 (i == 0) ? 7'd1 : MIDI_W'(127 - 7 * i), 7'd0, 7'd0);
        end
        // release of a note not held: stack kept, newest reselected
        play(KIND_OFF, 7'd5, 7'd0, 7'd0, 7'd0);
        // zero-velocity press releases the oldest copy of note 0
        play(KIND_ON, 7'd0, 7'd0, 7'd0, 7'd0);
        play(KIND_OFF, 7'd127, 7'd127, 7'd0, 7'd0);

        // --- random phases, each with its own control numbers and idling ---
        for (p = 0; p < PHASE_COUNT; p++) begin
            drain();
            case (p)
                0: begin
                    wave_cc_sel   = 7'd127;
                    detune_cc_sel = 7'd0;
                end
                1: begin
                    wave_cc_sel   = 7'd0;
                    detune_cc_sel = 7'd127;
                end
                2: begin
                    // same number in both registers
                    wave_cc_sel   = MIDI_W'($urandom_range(0, 127));
                    detune_cc_sel = wave_cc_sel;
                end
                3: begin
                    wave_cc_sel   = WAVE_CC_RESET;
                    detune_cc_sel = DETUNE_CC_RESET;
                end
                default: begin
                    wave_cc_sel   = MIDI_W'($urandom_range(0, 127));
                    detune_cc_sel = MIDI_W'($urandom_range(0, 127));
                end
            endcase
            write_reg(REG_WAVE_CC, wave_cc_sel);
            write_reg(REG_DETUNE_CC, detune_cc_sel);
            i_cfg_we <= 1'b0;

            // cycle through both idling, sender busy, receiver busy, neither
            evt_idle_on = (p % 2 == 0);
            res_idle_on = (p % 4 < 2);
            // alternate between filling the stack into overflow and draining it
            on_pct  = ((p / 2) % 2 == 0) ? 55 : 25;
            off_pct = ((p / 2) % 2 == 0) ? 30 : 55;

            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                next_event(on_pct, off_pct, ev);
                if (!is_ignored(ev)) begin
                    counted++;
                end
                send_event(ev);
            end
        end

        // --- wind down: collect everything, then watch for stray results ---
        drain();
        repeat (DEPTH + 8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== mono_note_priority_stack.f =====
hdl/nps_pkg.sv
hdl/nps_evt_if.sv
hdl/nps_res_if.sv
hdl/nps_core.sv
hdl/mono_note_priority_stack.sv
verif/nps_voice_check.sv
verif/tb_top.sv
